// ===== rtl/egf_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, widths and constants for the eased gain fader.
// No dependencies; every other file of the block uses it.
package egf_pkg;

  localparam int SAMPLE_BITS    = 24;
  localparam int GAIN_FRAC_BITS = 23;
  localparam int GW             = GAIN_FRAC_BITS + 1;
  localparam int SR_W           = 18;
  localparam int FADE_W         = 26;
  localparam int TIME_W         = 40;
  localparam int IDX_W          = 16;
  localparam int FORCE_W        = 2;
  localparam int US_PER_S       = 1000000;

  localparam int MUL_W0 = (SAMPLE_BITS > FADE_W) ? SAMPLE_BITS : FADE_W;
  localparam int MUL_W  = (GW > MUL_W0) ? GW : MUL_W0;
  localparam int DIV_W0 = GAIN_FRAC_BITS + 21;
  localparam int DIV_W  = (DIV_W0 > 44) ? DIV_W0 : 44;
  localparam int TW     = DIV_W + 2;

  localparam logic [GW-1:0]    UNITY    = GW'(1) << GAIN_FRAC_BITS;
  localparam logic [DIV_W-1:0] STEP_NUM = DIV_W'(US_PER_S) << GAIN_FRAC_BITS;

  localparam logic [FORCE_W-1:0] FORCE_AUTO = 2'd0;
  localparam logic [FORCE_W-1:0] FORCE_RISE = 2'd1;
  localparam logic [FORCE_W-1:0] FORCE_FALL = 2'd2;

  localparam logic [1:0] REG_SAMPLE_RATE = 2'd0;
  localparam logic [1:0] REG_FADE_IN     = 2'd1;
  localparam logic [1:0] REG_FADE_OUT    = 2'd2;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] sample_in;
    logic                          first_of_frame;
    logic [TIME_W-1:0]             block_time_us;
    logic [IDX_W-1:0]              frame_index;
    logic [TIME_W-1:0]             track_duration_us;
    logic [FORCE_W-1:0]            force_mode;
  } in_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] sample_out;
    logic [GW-1:0]                 gain_now;
    logic                          fade_out_done;
  } out_t;

  typedef struct packed {
    logic [SR_W-1:0]   frame_rate;
    logic [FADE_W-1:0] fade_in_us;
    logic [FADE_W-1:0] tail_fade_us;
  } cfg_t;

  typedef struct packed {
    logic busy;
    logic done;
  } unit_st_t;

endpackage

// ===== rtl/eased_gain_fader_core.sv =====
`timescale 1ns / 1ps
// Eased gain fader top level: sequencer around a serial multiplier and divider.
// At sample rate zero the sample passes through; a sample that is not first of a frame takes
// one multiplication, a first sample up to two divisions and four multiplications on the
// shared one-bit-per-cycle units; a held result stalls the sequencer until it is taken.
// One request at a time, taken in idle. Reset: async, active low, clears the control state.
module eased_gain_fader_core (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  egf_pkg::in_t     in_data_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output egf_pkg::out_t    out_data_o,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [3:0]       paddr,
  input  logic [31:0]      pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  localparam int SB  = egf_pkg::SAMPLE_BITS;
  localparam int GW  = egf_pkg::GW;
  localparam int GF  = egf_pkg::GAIN_FRAC_BITS;
  localparam int MW  = egf_pkg::MUL_W;
  localparam int DW  = egf_pkg::DIV_W;
  localparam int TW  = egf_pkg::TW;

  typedef enum logic [10:0] {
    ST_IDLE     = 11'b00000000001,
    ST_DECIDE   = 11'b00000000010,
    ST_FRM_DIV  = 11'b00000000100,
    ST_STEP     = 11'b00000001000,
    ST_STEP_MUL = 11'b00000010000,
    ST_STEP_DIV = 11'b00000100000,
    ST_SLEW     = 11'b00001000000,
    ST_SQ_MUL   = 11'b00010000000,
    ST_EASE_MUL = 11'b00100000000,
    ST_SMP_MUL  = 11'b01000000000,
    ST_HOLD     = 11'b10000000000
  } state_e;

  state_e state_q, state_d;

  egf_pkg::cfg_t     cfg;
  egf_pkg::in_t      in_q;
  egf_pkg::unit_st_t mul_st, div_st;

  logic [DW-1:0]   num_q;
  logic [GW-1:0]   gain_q, gain_d, start_q, start_d, prog_q, prog_d, step_q, step_d;
  logic            tgt_q, tgt_d, seg_tgt_q, seg_tgt_d, live_q, live_d;
  logic            loaded_q, loaded_d, done_q, done_d;
  logic [1:0]      last_force_q, last_force_d;
  logic [egf_pkg::FADE_W-1:0] fade_q, fade_d;
  logic [SB-1:0]   res_q, res_d, mag;
  logic            neg;
  logic            out_valid_q, out_valid_d;
  egf_pkg::out_t   out_q, out_d;

  logic            mul_start, div_start;
  logic [MW-1:0]   mul_a, mul_b;
  logic [2*MW-1:0] prod;
  logic [DW-1:0]   div_num, div_den, quo;

  logic [GW:0]     prog_sum;
  logic [GW-1:0]   prog_base, mprod_hi, gain_new, diff;
  logic signed [TW-1:0] remaining;

  egf_cfg_regs u_cfg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .psel_i    (psel),
    .penable_i (penable),
    .pwrite_i  (pwrite),
    .paddr_i   (paddr),
    .pwdata_i  (pwdata),
    .prdata_o  (prdata),
    .pready_o  (pready),
    .cfg_o     (cfg)
  );

  egf_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .st_o    (mul_st),
    .prod_o  (prod)
  );

  egf_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .st_o    (div_st),
    .quo_o   (quo)
  );

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  assign neg      = in_q.sample_in[SB-1];
  assign mag      = neg ? (SB'(0) - in_q.sample_in) : in_q.sample_in;
  assign mprod_hi = GW'(prod >> GF);
  assign gain_new = tgt_q ? (start_q + mprod_hi) : (start_q - mprod_hi);
  assign diff     = tgt_q ? (egf_pkg::UNITY - start_q) : start_q;
  assign remaining = TW'(in_q.track_duration_us) - TW'(in_q.block_time_us) - TW'(quo);
  assign prog_base = (!live_q || (tgt_q != seg_tgt_q)) ? '0 : prog_q;
  assign prog_sum  = {1'b0, prog_base} + {1'b0, step_q};

  always_comb begin
    state_d      = state_q;
    gain_d       = gain_q;
    start_d      = start_q;
    prog_d       = prog_q;
    step_d       = step_q;
    tgt_d        = tgt_q;
    seg_tgt_d    = seg_tgt_q;
    live_d       = live_q;
    loaded_d     = loaded_q;
    done_d       = done_q;
    last_force_d = last_force_q;
    fade_d       = fade_q;
    res_d        = res_q;
    out_valid_d  = out_valid_q & ~out_ready_i;
    out_d        = out_q;
    mul_start    = 1'b0;
    mul_a        = '0;
    mul_b        = '0;
    div_start    = 1'b0;
    div_num      = num_q;
    div_den      = DW'(cfg.frame_rate);

    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          if (!loaded_q) begin
            gain_d   = (cfg.fade_in_us != '0) ? '0 : egf_pkg::UNITY;
            loaded_d = 1'b1;
          end
          if (in_data_i.force_mode != last_force_q) begin
            done_d       = 1'b0;
            last_force_d = in_data_i.force_mode;
          end
          if (cfg.frame_rate == '0) begin
            res_d   = in_data_i.sample_in;
            state_d = ST_HOLD;
          end else begin
            state_d = ST_DECIDE;
          end
        end
      end
      ST_DECIDE: begin
        if (!in_q.first_of_frame) begin
          mul_start = 1'b1;
          mul_a     = MW'(mag);
          mul_b     = MW'(gain_q);
          state_d   = ST_SMP_MUL;
        end else if (in_q.force_mode == egf_pkg::FORCE_RISE) begin
          tgt_d   = 1'b1;
          fade_d  = cfg.fade_in_us;
          state_d = ST_STEP;
        end else if (in_q.force_mode == egf_pkg::FORCE_FALL) begin
          tgt_d   = 1'b0;
          fade_d  = cfg.tail_fade_us;
          state_d = ST_STEP;
        end else if (cfg.tail_fade_us != '0 && in_q.track_duration_us != '0) begin
          div_start = 1'b1;
          state_d   = ST_FRM_DIV;
        end else begin
          tgt_d   = 1'b1;
          fade_d  = cfg.fade_in_us;
          state_d = ST_STEP;
        end
      end
      ST_FRM_DIV: begin
        if (div_st.done) begin
          if (remaining < $signed(TW'(cfg.tail_fade_us))) begin
            tgt_d  = 1'b0;
            fade_d = cfg.tail_fade_us;
          end else begin
            tgt_d  = 1'b1;
            fade_d = cfg.fade_in_us;
          end
          state_d = ST_STEP;
        end
      end
      ST_STEP: begin
        if (fade_q == '0) begin
          step_d  = egf_pkg::UNITY;
          state_d = ST_SLEW;
        end else begin
          mul_start = 1'b1;
          mul_a     = MW'(fade_q);
          mul_b     = MW'(cfg.frame_rate);
          state_d   = ST_STEP_MUL;
        end
      end
      ST_STEP_MUL: begin
        if (mul_st.done) begin
          div_start = 1'b1;
          div_num   = egf_pkg::STEP_NUM;
          div_den   = DW'(prod);
          state_d   = ST_STEP_DIV;
        end
      end
      ST_STEP_DIV: begin
        if (div_st.done) begin
          if (quo == '0) begin
            step_d = GW'(1);
          end else if (quo > DW'(egf_pkg::UNITY)) begin
            step_d = egf_pkg::UNITY;
          end else begin
            step_d = GW'(quo);
          end
          state_d = ST_SLEW;
        end
      end
      ST_SLEW: begin
        if (!live_q || (tgt_q != seg_tgt_q)) begin
          start_d   = gain_q;
          seg_tgt_d = tgt_q;
          live_d    = 1'b1;
        end
        prog_d    = (prog_sum > {1'b0, egf_pkg::UNITY}) ? egf_pkg::UNITY : GW'(prog_sum);
        mul_start = 1'b1;
        mul_a     = MW'(prog_d);
        mul_b     = MW'(prog_d);
        state_d   = ST_SQ_MUL;
      end
      ST_SQ_MUL: begin
        if (mul_st.done) begin
          mul_start = 1'b1;
          mul_a     = MW'(diff);
          mul_b     = MW'(mprod_hi);
          state_d   = ST_EASE_MUL;
        end
      end
      ST_EASE_MUL: begin
        if (mul_st.done) begin
          gain_d = gain_new;
          if (in_q.force_mode == egf_pkg::FORCE_FALL && gain_new == '0) begin
            done_d = 1'b1;
          end
          mul_start = 1'b1;
          mul_a     = MW'(mag);
          mul_b     = MW'(gain_new);
          state_d   = ST_SMP_MUL;
        end
      end
      ST_SMP_MUL: begin
        if (mul_st.done) begin
          res_d   = neg ? (SB'(0) - SB'(prod >> GF)) : SB'(prod >> GF);
          state_d = ST_HOLD;
        end
      end
      ST_HOLD: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d         = 1'b1;
          out_d.sample_out    = res_q;
          out_d.gain_now      = gain_q;
          out_d.fade_out_done = done_q;
          state_d             = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      gain_q       <= '0;
      start_q      <= '0;
      prog_q       <= '0;
      seg_tgt_q    <= 1'b0;
      live_q       <= 1'b0;
      loaded_q     <= 1'b0;
      done_q       <= 1'b0;
      last_force_q <= egf_pkg::FORCE_AUTO;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      gain_q       <= gain_d;
      start_q      <= start_d;
      prog_q       <= prog_d;
      seg_tgt_q    <= seg_tgt_d;
      live_q       <= live_d;
      loaded_q     <= loaded_d;
      done_q       <= done_d;
      last_force_q <= last_force_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_q  <= in_data_i;
      num_q <= DW'(in_data_i.frame_index) * DW'(egf_pkg::US_PER_S);
    end
    step_q  <= step_d;
    tgt_q   <= tgt_d;
    fade_q  <= fade_d;
    res_q   <= res_d;
    out_q   <= out_d;
  end

endmodule

// ===== rtl/egf_cfg_regs.sv =====
`timescale 1ns / 1ps
// APB-style configuration registers of the eased gain fader.
// Depends on egf_pkg.
module egf_cfg_regs (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel_i,
  input  logic              penable_i,
  input  logic              pwrite_i,
  input  logic [3:0]        paddr_i,
  input  logic [31:0]       pwdata_i,
  output logic [31:0]       prdata_o,
  output logic              pready_o,
  output egf_pkg::cfg_t     cfg_o
);

  egf_pkg::cfg_t cfg_q, cfg_d;
  logic          wr_en;

  assign pready_o = 1'b1;
  assign wr_en    = psel_i & penable_i & pwrite_i;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (paddr_i[3:2])
        egf_pkg::REG_SAMPLE_RATE: cfg_d.frame_rate   = pwdata_i[egf_pkg::SR_W-1:0];
        egf_pkg::REG_FADE_IN:     cfg_d.fade_in_us   = pwdata_i[egf_pkg::FADE_W-1:0];
        egf_pkg::REG_FADE_OUT:    cfg_d.tail_fade_us = pwdata_i[egf_pkg::FADE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr_i[3:2])
      egf_pkg::REG_SAMPLE_RATE: prdata_o = 32'(cfg_q.frame_rate);
      egf_pkg::REG_FADE_IN:     prdata_o = 32'(cfg_q.fade_in_us);
      egf_pkg::REG_FADE_OUT:    prdata_o = 32'(cfg_q.tail_fade_us);
      default:                  prdata_o = 32'd0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.frame_rate   <= egf_pkg::SR_W'(48000);
      cfg_q.fade_in_us   <= '0;
      cfg_q.tail_fade_us <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== rtl/egf_mul.sv =====
`timescale 1ns / 1ps
// Bit-serial unsigned shift-add multiplier, one multiplier bit per cycle.
// Depends on egf_pkg.
module egf_mul (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [egf_pkg::MUL_W-1:0]     a_i,
  input  logic [egf_pkg::MUL_W-1:0]     b_i,
  output egf_pkg::unit_st_t             st_o,
  output logic [2*egf_pkg::MUL_W-1:0]   prod_o
);

  localparam int W  = egf_pkg::MUL_W;
  localparam int CW = $clog2(W);

  logic [W-1:0]  a_q, hi_q, lo_q;
  logic [CW-1:0] cnt_q;
  logic          busy_q, done_q;
  logic [W:0]    sum;

  assign sum = {1'b0, hi_q} + (lo_q[0] ? {1'b0, a_q} : '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CW'(W - 1);
      end else if (busy_q) begin
        cnt_q <= cnt_q - CW'(1);
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q  <= a_i;
      hi_q <= '0;
      lo_q <= b_i;
    end else if (busy_q) begin
      hi_q <= sum[W:1];
      lo_q <= {sum[0], lo_q[W-1:1]};
    end
  end

  assign st_o.busy = busy_q;
  assign st_o.done = done_q;
  assign prod_o    = {hi_q, lo_q};

endmodule

// ===== rtl/egf_div.sv =====
`timescale 1ns / 1ps
// Bit-serial restoring divider, one quotient bit per cycle.
// Depends on egf_pkg.
module egf_div (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [egf_pkg::DIV_W-1:0]   num_i,
  input  logic [egf_pkg::DIV_W-1:0]   den_i,
  output egf_pkg::unit_st_t           st_o,
  output logic [egf_pkg::DIV_W-1:0]   quo_o
);

  localparam int W  = egf_pkg::DIV_W;
  localparam int CW = $clog2(W);

  logic [W-1:0]  den_q, quo_q;
  logic [W:0]    rem_q, rem_sh;
  logic [CW-1:0] cnt_q;
  logic          busy_q, done_q, fits;

  assign rem_sh = {rem_q[W-1:0], quo_q[W-1]};
  assign fits   = rem_sh >= {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CW'(W - 1);
      end else if (busy_q) begin
        cnt_q <= cnt_q - CW'(1);
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      den_q <= den_i;
      quo_q <= num_i;
      rem_q <= '0;
    end else if (busy_q) begin
      rem_q <= fits ? (rem_sh - {1'b0, den_q}) : rem_sh;
      quo_q <= {quo_q[W-2:0], fits};
    end
  end

  assign st_o.busy = busy_q;
  assign st_o.done = done_q;
  assign quo_o     = quo_q;

endmodule

// ===== rtl/egf_checker.sv =====
`timescale 1ns / 1ps
// Port-level checker for the eased gain fader, bound to the top level.
// Depends on egf_pkg and eased_gain_fader_core.
module egf_checker (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          in_valid_i,
  input logic          in_ready_o,
  input logic          out_valid_o,
  input logic          out_ready_i,
  input egf_pkg::out_t out_data_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result changed");

  a_gain_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.gain_now <= egf_pkg::UNITY)
    else $error("gain above unity");

  a_done_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.fade_out_done |-> out_data_o.gain_now == '0)
    else $error("fade-out done with nonzero gain");

  a_one_request: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("second request taken while busy");

endmodule

bind eased_gain_fader_core egf_checker u_egf_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);
